@@ src/nfa_dfa_pkg.sv @@
// ---------------------------------------------------------------------------
// NFA to DFA subset construction: shared types and constants
// Request and response payloads, the controller command and status
// groups, and the field widths fixed by the interface.
// ---------------------------------------------------------------------------
`default_nettype none

package nfa_dfa_pkg;

   localparam int MAX_NFA_STATES_DEF = 6;
   localparam int STATE_W            = 3;
   localparam int MASK_W             = 6;
   localparam int COUNT_W            = 3;
   localparam int STATE_COUNT_RESET  = 6;

   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_RUN  = 1'b1;

   typedef struct packed {
      logic               req_type;
      logic [STATE_W-1:0] from_state;
      logic               symbol;
      logic [STATE_W-1:0] to_state;
   } req_item_type;

   typedef struct packed {
      logic [MASK_W-1:0] subset_mask;
      logic [MASK_W-1:0] next_on_zero;
      logic [MASK_W-1:0] next_on_one;
      logic              last_row;
   } rsp_item_type;

   typedef struct packed {
      logic load_rule;
      logic start;
      logic init_mark;
      logic wl_read;
      logic wl_mark;
      logic wl_sym;
      logic head_inc;
      logic scan_step;
      logic flush_push;
      logic finish;
   } dp_cmd_type;

   typedef struct packed {
      logic run_req;
      logic init_last;
      logic wl_empty;
      logic scan_marked;
      logic scan_last;
      logic pend_valid;
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

@@ src/nfa_to_dfa_subset_construction.sv @@
// ---------------------------------------------------------------------------
// NFA to DFA subset construction
// Loads NFA transition rules over a two-symbol alphabet and on a run
// request emits the DFA table in ascending subset mask order.
// ---------------------------------------------------------------------------
// A rule request leaves the block ready again the next cycle. A run
// request first marks the target of every rule entry within the state
// count, then walks the worklist with a registered worklist read and one
// step for each symbol per queued subset, since only one subset can be
// marked and queued per cycle. It then scans all 2^MAX_NFA_STATES subset
// codes, one per cycle except while a marked code waits for the response
// side, and ends with a flush step. Subset marks live in flip-flops that
// reset and the end of a run clear, so no clearing pass follows reset.
// The csr_data register (state count) is accepted every cycle and must
// be written only while the block is idle.
`default_nettype none

module nfa_to_dfa_subset_construction
   import nfa_dfa_pkg::*;
#(
   parameter int MAX_NFA_STATES = MAX_NFA_STATES_DEF
)
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire req_item_type       req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output rsp_item_type            rsp_data,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [COUNT_W-1:0] csr_data
);

   dp_cmd_type    cmd;
   dp_status_type status;

   nfa_dfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   nfa_dfa_datapath #(
      .MAX_NFA_STATES (MAX_NFA_STATES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

@@ src/nfa_dfa_ctrl.sv @@
// ---------------------------------------------------------------------------
// NFA to DFA subset construction: controller
// Sequences rule loads and the phases of a run: singleton marking,
// worklist walk, ascending scan of marked subsets and final flush.
// ---------------------------------------------------------------------------
`default_nettype none

module nfa_dfa_ctrl
   import nfa_dfa_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire dp_status_type status,
   output dp_cmd_type         cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INIT,
      ST_WL_READ,
      ST_SYM0,
      ST_SYM1,
      ST_SCAN,
      ST_FLUSH
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;
   logic           req_ready_ff;

   assign req_ready = req_ready_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (status.run_req) begin
                  cmd.start = 1'b1;
                  state_in  = ST_INIT;
               end else begin
                  cmd.load_rule = 1'b1;
               end
            end
         end
         ST_INIT: begin
            cmd.init_mark = 1'b1;
            if (status.init_last) begin
               state_in = ST_WL_READ;
            end
         end
         ST_WL_READ: begin
            if (status.wl_empty) begin
               state_in = ST_SCAN;
            end else begin
               cmd.wl_read = 1'b1;
               state_in    = ST_SYM0;
            end
         end
         ST_SYM0: begin
            cmd.wl_mark = 1'b1;
            cmd.wl_sym  = 1'b0;
            state_in    = ST_SYM1;
         end
         ST_SYM1: begin
            cmd.wl_mark  = 1'b1;
            cmd.wl_sym   = 1'b1;
            cmd.head_inc = 1'b1;
            state_in     = ST_WL_READ;
         end
         ST_SCAN: begin
            // A marked subset pushes the held row out, so it waits for room.
            if (!(status.scan_marked && status.pend_valid && !status.out_free)) begin
               cmd.scan_step = 1'b1;
               if (status.scan_last) begin
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_FLUSH: begin
            if (!status.pend_valid) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end else if (status.out_free) begin
               cmd.flush_push = 1'b1;
               cmd.finish     = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         req_ready_ff <= 1'b1;
      end else begin
         state_ff     <= state_in;
         req_ready_ff <= (state_in == ST_IDLE);
      end
   end

endmodule

`default_nettype wire

@@ src/nfa_dfa_datapath.sv @@
// ---------------------------------------------------------------------------
// NFA to DFA subset construction: datapath
// Rule masks, subset marks, worklist memory, scan counter, held row and
// the response register, driven by the controller commands.
// ---------------------------------------------------------------------------
`default_nettype none

module nfa_dfa_datapath
   import nfa_dfa_pkg::*;
#(
   parameter int MAX_NFA_STATES = MAX_NFA_STATES_DEF
)
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire dp_cmd_type         cmd,
   output dp_status_type           status,
   input  wire req_item_type       req_data,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [COUNT_W-1:0] csr_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output rsp_item_type            rsp_data
);

   localparam int M   = MAX_NFA_STATES;
   localparam int SC  = 1 << M;
   localparam int NR  = 2 * M;
   localparam int RIW = $clog2(NR);
   localparam int NW  = $clog2(M + 1);
   localparam int CW  = (NW > STATE_W) ? NW : STATE_W;

   logic [COUNT_W-1:0] state_count_ff;
   logic [CW-1:0]      n_live;
   logic [M-1:0]       used;

   logic [M-1:0]       rule_ff [NR];
   logic [M-1:0]       single0 [M];
   logic [M-1:0]       single1 [M];

   logic               rule_ok;
   logic [STATE_W:0]   ridx_full;
   logic [RIW-1:0]     ridx;
   logic [M-1:0]       to_bit;

   logic [RIW-1:0]     init_idx_ff;
   logic               init_in_range;

   logic [SC-1:0]      marked_ff;
   logic [M:0]         tail_ff;
   logic [M:0]         head_ff;
   logic [M-1:0]       wl_mem [SC];
   logic [M-1:0]       wl_rd_ff;
   logic [M-1:0]       wl_acc;

   logic               mark_en;
   logic [M-1:0]       mark_val;
   logic               mark_new;

   logic [M-1:0]       scan_idx_ff;
   logic [M-1:0]       row_n0;
   logic [M-1:0]       row_n1;

   logic               pend_valid_ff;
   logic [M-1:0]       pend_mask_ff;
   logic [M-1:0]       pend_n0_ff;
   logic [M-1:0]       pend_n1_ff;

   logic               push_mid;
   logic               push_any;
   logic               rsp_valid_ff;
   rsp_item_type       rsp_data_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_count_ff <= COUNT_W'(STATE_COUNT_RESET);
      end else if (csr_valid) begin
         state_count_ff <= csr_data;
      end
   end

   // An oversized state count acts as the largest supported one.
   always_comb begin
      if (CW'(state_count_ff) > CW'(M)) begin
         n_live = CW'(M);
      end else begin
         n_live = CW'(state_count_ff);
      end
      for (int k = 0; k < M; k++) begin
         used[k] = (CW'(k) < n_live);
      end
   end

   always_comb begin
      for (int k = 0; k < M; k++) begin
         single0[k] = rule_ff[2 * k] & used;
         single1[k] = rule_ff[2 * k + 1] & used;
      end
   end

   // Rule load.
   assign rule_ok   = (CW'(req_data.from_state) < n_live) && (CW'(req_data.to_state) < n_live);
   assign ridx_full = {req_data.from_state, req_data.symbol};
   assign ridx      = ridx_full[RIW-1:0];

   always_comb begin
      for (int k = 0; k < M; k++) begin
         to_bit[k] = (CW'(req_data.to_state) == CW'(k));
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.finish) begin
         for (int r = 0; r < NR; r++) begin
            rule_ff[r] <= '0;
         end
      end else if (cmd.load_rule && rule_ok) begin
         rule_ff[ridx] <= rule_ff[ridx] | to_bit;
      end
   end

   // Singleton phase walks every (state, symbol) rule entry.
   assign init_in_range = ((CW + 1)'(init_idx_ff) < {n_live, 1'b0});

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         init_idx_ff <= '0;
      end else if (cmd.init_mark) begin
         init_idx_ff <= init_idx_ff + 1'b1;
      end
   end

   // Worklist walk: OR of the singleton targets of the member states.
   always_comb begin
      wl_acc = '0;
      for (int k = 0; k < M; k++) begin
         if (wl_rd_ff[k]) begin
            wl_acc = wl_acc | (cmd.wl_sym ? single1[k] : single0[k]);
         end
      end
   end

   always_comb begin
      mark_en  = 1'b0;
      mark_val = wl_acc;
      if (cmd.init_mark) begin
         mark_en  = init_in_range;
         mark_val = rule_ff[init_idx_ff] & used;
      end else if (cmd.wl_mark) begin
         mark_en  = 1'b1;
         mark_val = wl_acc;
      end
   end

   assign mark_new = mark_en && !marked_ff[mark_val];

   always_ff @(posedge clock) begin
      if (reset || cmd.finish) begin
         marked_ff <= '0;
      end else if (mark_en) begin
         marked_ff[mark_val] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.start) begin
         tail_ff <= '0;
         head_ff <= '0;
      end else begin
         if (mark_new) begin
            tail_ff <= tail_ff + 1'b1;
         end
         if (cmd.head_inc) begin
            head_ff <= head_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mark_new) begin
         wl_mem[tail_ff[M-1:0]] <= mark_val;
      end
      if (cmd.wl_read) begin
         wl_rd_ff <= wl_mem[head_ff[M-1:0]];
      end
   end

   // Ascending scan; each marked row is held until the next marked row or the
   // flush, so the final one can carry the last-row flag.
   always_comb begin
      row_n0 = '0;
      row_n1 = '0;
      for (int k = 0; k < M; k++) begin
         if (scan_idx_ff[k]) begin
            row_n0 = row_n0 | single0[k];
            row_n1 = row_n1 | single1[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         scan_idx_ff <= '0;
      end else if (cmd.scan_step) begin
         scan_idx_ff <= scan_idx_ff + 1'b1;
      end
   end

   assign push_mid = cmd.scan_step && marked_ff[scan_idx_ff] && pend_valid_ff;
   assign push_any = push_mid || cmd.flush_push;

   always_ff @(posedge clock) begin
      if (reset || cmd.start || cmd.finish) begin
         pend_valid_ff <= 1'b0;
      end else if (cmd.scan_step && marked_ff[scan_idx_ff]) begin
         pend_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_step && marked_ff[scan_idx_ff]) begin
         pend_mask_ff <= scan_idx_ff;
         pend_n0_ff   <= row_n0;
         pend_n1_ff   <= row_n1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (push_any) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (push_any) begin
         rsp_data_ff.subset_mask  <= MASK_W'(pend_mask_ff);
         rsp_data_ff.next_on_zero <= MASK_W'(pend_n0_ff);
         rsp_data_ff.next_on_one  <= MASK_W'(pend_n1_ff);
         rsp_data_ff.last_row     <= cmd.flush_push;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      status.run_req     = (req_data.req_type == REQ_RUN);
      status.init_last   = (init_idx_ff == RIW'(NR - 1));
      status.wl_empty    = (head_ff == tail_ff);
      status.scan_marked = marked_ff[scan_idx_ff];
      status.scan_last   = &scan_idx_ff;
      status.pend_valid  = pend_valid_ff;
      status.out_free    = !rsp_valid_ff || rsp_ready;
   end

endmodule

`default_nettype wire

@@ src/nfa_dfa_checker.sv @@
// ---------------------------------------------------------------------------
// NFA to DFA subset construction: port checker
// Concurrent checks on the top-level ports, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module nfa_dfa_checker
   import nfa_dfa_pkg::*;
(
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_ready,
   input wire req_item_type       req_data,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire rsp_item_type       rsp_data,
   input wire logic               csr_valid,
   input wire logic               csr_ready,
   input wire logic [COUNT_W-1:0] csr_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // A run request occupies the block, so it is busy right after.
   a_run_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_data.req_type == REQ_RUN) |=> !req_ready)
      else $error("ready stayed high after a run request");

   a_load_ready: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_data.req_type == REQ_LOAD) |=> req_ready)
      else $error("rule load did not leave the block ready");

   // Only the final row of a table can still be waiting once the block is idle.
   a_row_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last_row |-> !req_ready)
      else $error("inner table row while ready for a request");

endmodule

bind nfa_to_dfa_subset_construction nfa_dfa_checker u_checker (.*);

`default_nettype wire

@@ sim/nfa_to_dfa_subset_construction_tb.sv @@
// ---------------------------------------------------------------------------
// Testbench for the NFA to DFA subset construction block
// Loads transition rules, runs the construction under several state counts
// and checks every emitted DFA row against a built-in table builder, with
// random idle bursts on the request and response sides.
// ---------------------------------------------------------------------------
`default_nettype none

module nfa_to_dfa_subset_construction_tb;
   import nfa_dfa_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NFA_STATES    = MAX_NFA_STATES_DEF;
   localparam int SUBSETS       = 1 << NFA_STATES;
   // Marking, worklist walk, full scan, flush.
   localparam int SETTLE_CYCLES = 400;
   localparam int LIMIT_CYCLES  = 2_000_000;
   localparam int RANDOM_ITEMS  = 450;
   localparam int QUIET_TAIL    = 70;

   class dfa_table_board;
      logic [COUNT_W-1:0] state_count;
      logic [MASK_W-1:0]  rule_masks [2*NFA_STATES];
      logic [MASK_W-1:0]  subset_next [SUBSETS][2];
      bit                 marked_set [SUBSETS];
      int unsigned        worklist [SUBSETS];
      int unsigned        wl_count;
      rsp_item_type       expected_rows [$];
      int                 errors;
      int                 runs;
      int                 rows_checked;

      function new();
         state_count = COUNT_W'(STATE_COUNT_RESET);
         foreach (rule_masks[i]) rule_masks[i] = '0;
         foreach (subset_next[i, j]) subset_next[i][j] = '0;
         foreach (marked_set[i]) marked_set[i] = 1'b0;
         wl_count     = 0;
         errors       = 0;
         runs         = 0;
         rows_checked = 0;
      endfunction

      function int unsigned active_states(int unsigned count);
         return (count > NFA_STATES) ? NFA_STATES : count;
      endfunction

      function void mark_subset(int unsigned m);
         m = m & (SUBSETS - 1);
         if (!marked_set[m] && wl_count < SUBSETS) begin
            worklist[wl_count] = m;
            wl_count++;
         end
         marked_set[m] = 1'b1;
      endfunction

      // Returns 1 when the request has any effect on the block.
      function bit note_request(req_item_type item);
         int unsigned  n;
         int unsigned  used;
         int unsigned  dest;
         int unsigned  cur;
         int unsigned  acc;
         int           top;
         rsp_item_type row;
         n    = active_states(state_count);
         used = (1 << n) - 1;
         if (item.req_type == REQ_LOAD) begin
            if (item.from_state < n && item.to_state < n) begin
               rule_masks[item.from_state * 2 + item.symbol] |= MASK_W'(1 << item.to_state);
               return 1'b1;
            end
            return 1'b0;
         end

         runs++;
         wl_count = 0;
         for (int i = 0; i < n; i++) begin
            for (int j = 0; j < 2; j++) begin
               dest = rule_masks[i * 2 + j] & used;
               subset_next[1 << i][j] = MASK_W'(dest);
               mark_subset(dest);
            end
         end

         for (int unsigned head = 0; head < wl_count; head++) begin
            cur = worklist[head];
            for (int j = 0; j < 2; j++) begin
               acc = 0;
               for (int k = 0; k < n; k++)
                  if (cur[k]) acc |= subset_next[1 << k][j];
               if (cur != 0) subset_next[cur][j] = MASK_W'(acc);
               mark_subset(acc);
            end
         end

         top = -1;
         for (int m = 0; m < SUBSETS; m++)
            if (marked_set[m]) top = m;
         for (int m = 0; m <= top; m++) begin
            if (marked_set[m]) begin
               row.subset_mask  = MASK_W'(m);
               row.next_on_zero = subset_next[m][0];
               row.next_on_one  = subset_next[m][1];
               row.last_row     = (m == top);
               expected_rows.push_back(row);
            end
         end

         foreach (rule_masks[i]) rule_masks[i] = '0;
         foreach (marked_set[i]) marked_set[i] = 1'b0;
         wl_count = 0;
         return 1'b1;
      endfunction

      function void check_row(rsp_item_type got);
         rsp_item_type want;
         if (expected_rows.size() == 0) begin
            errors++;
            $display("[%0t] unexpected row: expected none, got %h/%h/%h last %b", $time,
                     got.subset_mask, got.next_on_zero, got.next_on_one, got.last_row);
            return;
         end
         want = expected_rows.pop_front();
         rows_checked++;
         if (got.subset_mask !== want.subset_mask) begin
            errors++;
            $display("[%0t] subset_mask: expected %h, got %h", $time,
                     want.subset_mask, got.subset_mask);
         end
         if (got.next_on_zero !== want.next_on_zero) begin
            errors++;
            $display("[%0t] next_on_zero of %h: expected %h, got %h", $time,
                     want.subset_mask, want.next_on_zero, got.next_on_zero);
         end
         if (got.next_on_one !== want.next_on_one) begin
            errors++;
            $display("[%0t] next_on_one of %h: expected %h, got %h", $time,
                     want.subset_mask, want.next_on_one, got.next_on_one);
         end
         if (got.last_row !== want.last_row) begin
            errors++;
            $display("[%0t] last_row of %h: expected %b, got %b", $time,
                     want.subset_mask, want.last_row, got.last_row);
         end
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   req_item_type       req_data;
   logic               rsp_valid;
   logic               rsp_ready;
   rsp_item_type       rsp_data;
   logic               csr_valid;
   logic               csr_ready;
   logic [COUNT_W-1:0] csr_data;

   dfa_table_board sb;
   bit             quiet;
   int             kept_items;
   int             config_writes;
   int             rsp_hold;
   longint         cycle_count;

   nfa_to_dfa_subset_construction dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("nfa_to_dfa_subset_construction verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_row(rsp_data);
   end

   // Response side: random stall bursts between ready stretches.
   initial begin
      rsp_ready = 1'b0;
      rsp_hold  = 0;
      forever begin
         @(negedge clock);
         if (rsp_hold > 0) begin
            rsp_hold--;
         end else if (quiet) begin
            rsp_ready = 1'b1;
         end else if ($urandom_range(0, 2) == 0) begin
            rsp_ready = 1'b0;
            rsp_hold  = $urandom_range(1, 10) - 1;
         end else begin
            rsp_ready = 1'b1;
            rsp_hold  = $urandom_range(0, 15);
         end
      end
   end

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_request(input req_item_type item);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
      req_data  = item;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      if (sb.note_request(item)) kept_items++;
      @(negedge clock);
   endtask

   task automatic load_rule(input int from_st, input int sym, input int to_st);
      req_item_type item;
      item.req_type   = REQ_LOAD;
      item.from_state = STATE_W'(from_st);
      item.symbol     = sym[0];
      item.to_state   = STATE_W'(to_st);
      send_request(item);
   endtask

   task automatic run_table();
      req_item_type item;
      item.req_type   = REQ_RUN;
      item.from_state = STATE_W'($urandom_range(0, 7));
      item.symbol     = 1'($urandom_range(0, 1));
      item.to_state   = STATE_W'($urandom_range(0, 7));
      send_request(item);
   endtask

   // A run that emits nothing may still be scanning, hence the settle time.
   task automatic wait_idle();
      req_valid = 1'b0;
      while (sb.expected_rows.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_state_count(input int count);
      csr_data  = COUNT_W'(count);
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      sb.state_count = COUNT_W'(count);
      config_writes++;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   initial begin
      int plan [10] = '{2, 6, 4, 5, 6, 3, 1, 6, 7, 6};
      int target;
      int phase_end;
      int phase;
      int cfg;
      int n;
      int loads;

      sb            = new();
      quiet         = 1'b0;
      kept_items    = 0;
      config_writes = 0;
      cycle_count   = 0;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      csr_valid     = 1'b0;
      csr_data      = '0;
      repeat (5) @(negedge clock);
      reset = 1'b0;

      // With no rules every destination is the empty set.
      run_table();
      load_rule(0, 0, 1);
      load_rule(0, 1, 2);
      load_rule(1, 0, 5);
      load_rule(5, 1, 0);
      load_rule(5, 0, 5);
      load_rule(2, 1, 3);
      load_rule(6, 0, 1);
      load_rule(1, 1, 7);
      load_rule(7, 1, 7);
      run_table();

      // Rules loaded at full size, then the state count shrinks before the run.
      load_rule(0, 0, 5);
      load_rule(4, 1, 2);
      load_rule(1, 0, 1);
      load_rule(2, 0, 1);
      wait_idle();
      write_state_count(3);
      run_table();

      wait_idle();
      write_state_count(0);
      load_rule(0, 0, 0);
      run_table();

      wait_idle();
      write_state_count(7);
      load_rule(5, 1, 5);
      load_rule(0, 0, 5);
      load_rule(5, 0, 0);
      run_table();

      wait_idle();
      write_state_count(1);
      load_rule(0, 0, 0);
      load_rule(0, 1, 0);
      run_table();

      target = kept_items + RANDOM_ITEMS;
      phase  = 0;
      while (kept_items < target) begin
         cfg = (phase < 10) ? plan[phase] : $urandom_range(0, 7);
         phase++;
         wait_idle();
         write_state_count(cfg);
         n         = sb.active_states(cfg);
         phase_end = kept_items + 45;
         while (kept_items < phase_end && kept_items < target) begin
            if (kept_items >= target - QUIET_TAIL) quiet = 1'b1;
            loads = $urandom_range(0, 3 * n + 2);
            repeat (loads) begin
               if (n == 0 || $urandom_range(0, 7) == 0)
                  load_rule($urandom_range(0, 7), $urandom_range(0, 1), $urandom_range(0, 7));
               else
                  load_rule($urandom_range(0, n - 1), $urandom_range(0, 1),
                            $urandom_range(0, n - 1));
            end
            // Now and then the rules carry over into the next sequence.
            if ($urandom_range(0, 9) != 0) run_table();
         end
      end

      wait_idle();
      $display("Covered %0d runs and %0d DFA rows over %0d state count settings.",
               sb.runs, sb.rows_checked, config_writes);
      $display("Requests with an effect: %0d, mismatches: %0d.", kept_items, sb.errors);
      if (sb.errors == 0 && sb.expected_rows.size() == 0)
         $display("nfa_to_dfa_subset_construction verification clean");
      else
         $display("nfa_to_dfa_subset_construction verification failed");
      $finish;
   end

endmodule

`default_nettype wire

@@ sim.f @@
src/nfa_dfa_pkg.sv
src/nfa_dfa_ctrl.sv
src/nfa_dfa_datapath.sv
src/nfa_to_dfa_subset_construction.sv
src/nfa_dfa_checker.sv
sim/nfa_to_dfa_subset_construction_tb.sv
